// ===== rtl/assert_macros.svh =====
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define BCP_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("bcp assertion failed");

// same property, checked from the cycle after reset is released
`define BCP_ASSERT_POST(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        ($past(rst_n) |-> (prop))) else $error("bcp assertion failed");

`endif

// ===== rtl/bcp_pkg.sv =====
// package with types, constants and register codes of the barometer unit
package bcp_pkg;

    // shared serial multiplier widths
    localparam int MUL_AW = 64;
    localparam int MUL_BW = 24;

    // register indexes of the configuration port
    localparam logic [2:0] REG_C1 = 3'd0;
    localparam logic [2:0] REG_C2 = 3'd1;
    localparam logic [2:0] REG_C3 = 3'd2;
    localparam logic [2:0] REG_C4 = 3'd3;
    localparam logic [2:0] REG_C5 = 3'd4;
    localparam logic [2:0] REG_C6 = 3'd5;

    // compensation constants
    localparam logic signed [19:0] TEMP_BASE  = 20'sd2000;
    localparam logic signed [19:0] TEMP_LOW   = -20'sd1500;
    localparam logic signed [17:0] P_REF      = 18'sd101000;
    localparam logic [23:0]        ALT_CUBE_K = 24'd2308;

    // output limits
    localparam logic signed [63:0] TEMP_MIN = -64'sd4000;
    localparam logic signed [63:0] TEMP_MAX = 64'sd8500;
    localparam logic signed [63:0] PRES_MIN = 64'sd1000;
    localparam logic signed [63:0] PRES_MAX = 64'sd120000;
    localparam logic signed [32:0] ALT_MIN  = -33'sd2000000;
    localparam logic signed [32:0] ALT_MAX  = 33'sd2000000;
    localparam logic signed [43:0] GND_MIN  = -44'sd2147483648;
    localparam logic signed [43:0] GND_MAX  = 44'sd2147483647;

    // calibration words
    typedef struct packed {
        logic [15:0] c1;
        logic [15:0] c2;
        logic [15:0] c3;
        logic [15:0] c4;
        logic [15:0] c5;
        logic [15:0] c6;
    } cfg_t;

    // sequencer states, one launch and one wait state per multiply
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_TEMP_GO, ST_TEMP_WAIT,
        ST_OFF_GO,  ST_OFF_WAIT,
        ST_SENS_GO, ST_SENS_WAIT,
        ST_SQ_GO,   ST_SQ_WAIT,
        ST_CU_GO,   ST_CU_WAIT,
        ST_P_GO,    ST_P_WAIT,
        ST_D2_GO,   ST_D2_WAIT,
        ST_K_GO,    ST_K_WAIT,
        ST_D3_GO,   ST_D3_WAIT,
        ST_FINISH
    } state_t;

endpackage

// ===== rtl/bcp_stream_if.sv =====
// valid/ready channel interfaces for samples and results
interface bcp_in_if;
    logic        valid;
    logic        ready;
    logic [23:0] raw_pressure;
    logic [23:0] raw_temperature;

    modport source (output valid, output raw_pressure, output raw_temperature, input ready);
    modport sink (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

interface bcp_out_if;
    logic               valid;
    logic               ready;
    logic signed [14:0] temperature_centi;
    logic [16:0]        pressure_pa;
    logic signed [21:0] altitude_cm;
    logic               calibrating;

    modport source (output valid, output temperature_centi, output pressure_pa,
                    output altitude_cm, output calibrating, input ready);
    modport sink (input valid, input temperature_centi, input pressure_pa,
                  input altitude_cm, input calibrating, output ready);
endinterface

// ===== rtl/baro_pressure_compensation_altitude_unit.sv =====
// top level: barometer temperature, pressure and altitude compensation
//
//   channel     dir   protocol      transaction
//   sample_ch   in    valid/ready   raw_pressure, raw_temperature
//   result_ch   out   valid/ready   temperature_centi, pressure_pa, altitude_cm, calibrating
//   apb         in    apb write/rd  six 16-bit calibration words at 4*i
//
// one sample is processed at a time; all multiplies of the sequencer go through
// one shared shift-add multiplier that retires one multiplier bit per cycle and
// stops at the top set bit, with a launch and a wait state per multiply. reset
// clears the sample count, the ground offset and the calibration words. a new
// sample is taken while the last result still waits; a stalled result holds
// the sequencer in its last state.
module baro_pressure_compensation_altitude_unit import bcp_pkg::*;
#(
    parameter int CAL_SAMPLES  = 200,
    parameter int COPY_SAMPLES = 50
)
(
    input  logic        clk,
    input  logic        rst_n,
    bcp_in_if.sink      sample_ch,
    bcp_out_if.source   result_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [7:0] CAL_N  = 8'(CAL_SAMPLES);
    localparam logic [7:0] COPY_N = 8'(COPY_SAMPLES);

    cfg_t   cfg;
    state_t state_reg, state_next;

    // multiplier hookup
    logic                     mul_start;
    logic signed [MUL_AW-1:0] mul_a;
    logic [MUL_BW-1:0]        mul_b;
    logic                     mul_busy;
    logic signed [MUL_AW-1:0] mul_prod;

    // datapath registers
    logic [23:0]        d1_reg;
    logic signed [24:0] dt_reg;
    logic signed [19:0] temp_reg;
    logic signed [39:0] off_reg;
    logic signed [39:0] sens_reg;
    logic [39:0]        off2_reg;
    logic [39:0]        sens2_reg;
    logic signed [14:0] tsat_reg;
    logic [16:0]        psat_reg;
    logic signed [17:0] d_reg;
    logic signed [63:0] sq_reg;
    logic signed [31:0] alt_reg;

    // control registers
    logic [7:0]         cnt_reg;
    logic signed [31:0] gnd_reg;
    logic               out_valid_reg;

    // result register
    logic signed [14:0] out_temp_reg;
    logic [16:0]        out_pres_reg;
    logic signed [21:0] out_alt_reg;
    logic               out_cal_reg;

    logic accept, fin_load;

    bcp_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bcp_serial_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .busy  (mul_busy),
        .prod  (mul_prod)
    );

    assign accept   = sample_ch.valid && sample_ch.ready;
    assign fin_load = (state_reg == ST_FINISH) && (!out_valid_reg || result_ch.ready);

    // combinational helpers
    logic signed [19:0] sq_base, cu_base;
    logic [16:0]        d_abs;
    logic               d_neg;
    logic signed [39:0] sens_adj, off_adj;
    logic [39:0]        five_s, seven_u, eleven_u;
    logic signed [63:0] p_diff, pres64, t64, cube;

    assign sq_base  = TEMP_BASE - temp_reg;
    assign cu_base  = TEMP_LOW - temp_reg;
    assign d_neg    = d_reg[17];
    assign d_abs    = d_neg ? 17'(-d_reg) : d_reg[16:0];
    assign sens_adj = sens_reg - $signed(sens2_reg);
    assign off_adj  = off_reg - $signed(off2_reg);
    assign five_s   = (mul_prod[39:0] << 2) + mul_prod[39:0];
    assign seven_u  = (mul_prod[39:0] << 3) - mul_prod[39:0];
    assign eleven_u = (mul_prod[39:0] << 3) + (mul_prod[39:0] << 1) + mul_prod[39:0];
    assign p_diff   = (mul_prod >>> 21) - 64'(off_adj);
    assign pres64   = p_diff >>> 15;
    assign t64      = 64'(temp_reg);
    assign cube     = d_neg ? -mul_prod : mul_prod;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (accept) state_next = ST_TEMP_GO;
            ST_TEMP_GO:   state_next = ST_TEMP_WAIT;
            ST_TEMP_WAIT: if (!mul_busy) state_next = ST_OFF_GO;
            ST_OFF_GO:    state_next = ST_OFF_WAIT;
            ST_OFF_WAIT:  if (!mul_busy) state_next = ST_SENS_GO;
            ST_SENS_GO:   state_next = ST_SENS_WAIT;
            ST_SENS_WAIT:
                if (!mul_busy)
                    state_next = (temp_reg < TEMP_BASE) ? ST_SQ_GO : ST_P_GO;
            ST_SQ_GO:     state_next = ST_SQ_WAIT;
            ST_SQ_WAIT:
                if (!mul_busy)
                    state_next = (temp_reg < TEMP_LOW) ? ST_CU_GO : ST_P_GO;
            ST_CU_GO:     state_next = ST_CU_WAIT;
            ST_CU_WAIT:   if (!mul_busy) state_next = ST_P_GO;
            ST_P_GO:      state_next = ST_P_WAIT;
            ST_P_WAIT:    if (!mul_busy) state_next = ST_D2_GO;
            ST_D2_GO:     state_next = ST_D2_WAIT;
            ST_D2_WAIT:   if (!mul_busy) state_next = ST_K_GO;
            ST_K_GO:      state_next = ST_K_WAIT;
            ST_K_WAIT:    if (!mul_busy) state_next = ST_D3_GO;
            ST_D3_GO:     state_next = ST_D3_WAIT;
            ST_D3_WAIT:   if (!mul_busy) state_next = ST_FINISH;
            ST_FINISH:    if (fin_load) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // multiplier launch and operand select
    always_comb
    begin
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        case (state_reg)
            ST_TEMP_GO:
            begin
                mul_start = 1'b1;
                mul_a     = 64'(dt_reg);
                mul_b     = {8'h00, cfg.c6};
            end
            ST_OFF_GO:
            begin
                mul_start = 1'b1;
                mul_a     = 64'(dt_reg);
                mul_b     = {8'h00, cfg.c4};
            end
            ST_SENS_GO:
            begin
                mul_start = 1'b1;
                mul_a     = 64'(dt_reg);
                mul_b     = {8'h00, cfg.c3};
            end
            ST_SQ_GO:
            begin
                mul_start = 1'b1;
                mul_a     = 64'(sq_base);
                mul_b     = {4'h0, sq_base[19:0]};
            end
            ST_CU_GO:
            begin
                mul_start = 1'b1;
                mul_a     = 64'(cu_base);
                mul_b     = {4'h0, cu_base[19:0]};
            end
            ST_P_GO:
            begin
                mul_start = 1'b1;
                mul_a     = 64'(sens_adj);
                mul_b     = d1_reg;
            end
            ST_D2_GO:
            begin
                mul_start = 1'b1;
                mul_a     = 64'({1'b0, d_abs});
                mul_b     = {7'h00, d_abs};
            end
            ST_K_GO:
            begin
                mul_start = 1'b1;
                mul_a     = sq_reg;
                mul_b     = ALT_CUBE_K;
            end
            ST_D3_GO:
            begin
                mul_start = 1'b1;
                mul_a     = sq_reg;
                mul_b     = {7'h00, d_abs};
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    // calibration and relative altitude
    logic               cal;
    logic [7:0]         cnt_inc;
    logic signed [32:0] alt_diff;
    logic signed [42:0] gain_prod;
    logic signed [43:0] gnd_sum;
    logic signed [31:0] gnd_upd;
    logic signed [21:0] rel;

    assign cal       = cnt_reg < CAL_N;
    assign cnt_inc   = cnt_reg + 8'd1;
    assign alt_diff  = 33'(alt_reg) - 33'(gnd_reg);
    assign gain_prod = (43'(alt_diff) <<< 8) + (43'(alt_diff) <<< 7)
                     + (43'(alt_diff) <<< 4) + (43'(alt_diff) <<< 1);
    assign gnd_sum   = 44'(gnd_reg) + 44'(gain_prod >>> 8);
    assign gnd_upd   = (gnd_sum < GND_MIN) ? GND_MIN[31:0] :
                       (gnd_sum > GND_MAX) ? GND_MAX[31:0] : gnd_sum[31:0];
    assign rel       = (alt_diff < ALT_MIN) ? ALT_MIN[21:0] :
                       (alt_diff > ALT_MAX) ? ALT_MAX[21:0] : alt_diff[21:0];

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
                if (accept)
                begin
                    d1_reg    <= sample_ch.raw_pressure;
                    dt_reg    <= $signed({1'b0, sample_ch.raw_temperature})
                               - $signed({1'b0, cfg.c5, 8'h00});
                    off2_reg  <= '0;
                    sens2_reg <= '0;
                end
            ST_TEMP_WAIT:
                if (!mul_busy)
                    temp_reg <= TEMP_BASE + 20'(mul_prod >>> 23);
            ST_OFF_WAIT:
                if (!mul_busy)
                    off_reg <= $signed({8'h00, cfg.c2, 16'h0000}) + 40'(mul_prod >>> 7);
            ST_SENS_WAIT:
                if (!mul_busy)
                    sens_reg <= $signed({9'h000, cfg.c1, 15'h0000}) + 40'(mul_prod >>> 8);
            ST_SQ_WAIT:
                if (!mul_busy)
                begin
                    off2_reg  <= five_s >> 1;
                    sens2_reg <= five_s >> 2;
                end
            ST_CU_WAIT:
                if (!mul_busy)
                begin
                    off2_reg  <= off2_reg + seven_u;
                    sens2_reg <= sens2_reg + (eleven_u >> 1);
                end
            ST_P_WAIT:
                if (!mul_busy)
                begin
                    tsat_reg <= (t64 < TEMP_MIN) ? TEMP_MIN[14:0] :
                                (t64 > TEMP_MAX) ? TEMP_MAX[14:0] : temp_reg[14:0];
                    if (pres64 < PRES_MIN)
                    begin
                        psat_reg <= PRES_MIN[16:0];
                        d_reg    <= P_REF - 18'(PRES_MIN);
                    end
                    else if (pres64 > PRES_MAX)
                    begin
                        psat_reg <= PRES_MAX[16:0];
                        d_reg    <= P_REF - 18'(PRES_MAX);
                    end
                    else
                    begin
                        psat_reg <= pres64[16:0];
                        d_reg    <= P_REF - $signed({1'b0, pres64[16:0]});
                    end
                end
            ST_D2_WAIT, ST_K_WAIT:
                if (!mul_busy)
                    sq_reg <= mul_prod;
            ST_D3_WAIT:
                if (!mul_busy)
                    alt_reg <= (32'(d_reg) <<< 3) + 32'(d_reg) + 32'(cube >>> 48);
            default:
            begin
            end
        endcase
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (fin_load)
        begin
            out_temp_reg <= tsat_reg;
            out_pres_reg <= psat_reg;
            out_alt_reg  <= cal ? 22'sd0 : rel;
            out_cal_reg  <= cal;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            gnd_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (fin_load)
                out_valid_reg <= 1'b1;
            else if (result_ch.ready)
                out_valid_reg <= 1'b0;
            if (fin_load && cal)
            begin
                cnt_reg <= cnt_inc;
                gnd_reg <= (cnt_inc < COPY_N) ? alt_reg : gnd_upd;
            end
        end
    end

    assign sample_ch.ready          = (state_reg == ST_IDLE);
    assign result_ch.valid          = out_valid_reg;
    assign result_ch.temperature_centi = out_temp_reg;
    assign result_ch.pressure_pa    = out_pres_reg;
    assign result_ch.altitude_cm    = out_alt_reg;
    assign result_ch.calibrating    = out_cal_reg;

endmodule

// ===== rtl/bcp_serial_mul.sv =====
// bit-serial shift-add multiplier, one multiplier bit per cycle
module bcp_serial_mul import bcp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [MUL_AW-1:0] a,
    input  logic [MUL_BW-1:0]        b,
    output logic                     busy,
    output logic signed [MUL_AW-1:0] prod
);

    logic                     busy_reg, busy_next;
    logic signed [MUL_AW-1:0] a_reg, a_next;
    logic [MUL_BW-1:0]        b_reg, b_next;
    logic signed [MUL_AW-1:0] acc_reg, acc_next;

    // load operands or retire the lowest multiplier bit
    always_comb
    begin
        busy_next = busy_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            a_next    = a;
            b_next    = b;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            acc_next  = b_reg[0] ? acc_reg + a_reg : acc_reg;
            a_next    = a_reg <<< 1;
            b_next    = b_reg >> 1;
            busy_next = |b_reg[MUL_BW-1:1];
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else
            busy_reg <= busy_next;
    end

    // operand and accumulator shift registers
    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign busy = busy_reg;
    assign prod = acc_reg;

endmodule

// ===== rtl/bcp_cfg_regs.sv =====
// apb calibration word registers
module bcp_cfg_regs import bcp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t       cfg_reg, cfg_next;
    logic [2:0] idx;

    assign idx = paddr[4:2];

    // write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite && (paddr[1:0] == 2'b00))
        begin
            case (idx)
                REG_C1:  cfg_next.c1 = pwdata[15:0];
                REG_C2:  cfg_next.c2 = pwdata[15:0];
                REG_C3:  cfg_next.c3 = pwdata[15:0];
                REG_C4:  cfg_next.c4 = pwdata[15:0];
                REG_C5:  cfg_next.c5 = pwdata[15:0];
                REG_C6:  cfg_next.c6 = pwdata[15:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        case (idx)
            REG_C1:  prdata = {16'h0000, cfg_reg.c1};
            REG_C2:  prdata = {16'h0000, cfg_reg.c2};
            REG_C3:  prdata = {16'h0000, cfg_reg.c3};
            REG_C4:  prdata = {16'h0000, cfg_reg.c4};
            REG_C5:  prdata = {16'h0000, cfg_reg.c5};
            REG_C6:  prdata = {16'h0000, cfg_reg.c6};
            default: prdata = 32'h0000_0000;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    assign pready = 1'b1;
    assign cfg    = cfg_reg;

endmodule

// ===== rtl/bcp_checker.sv =====
// port-level checker for the barometer unit, bound to the top level
`include "assert_macros.svh"

module bcp_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [14:0] temperature_centi,
    input logic [16:0]        pressure_pa,
    input logic signed [21:0] altitude_cm,
    input logic               calibrating
);

    // a pending result stays offered
    `BCP_ASSERT_POST(a_valid_hold, $past(out_valid && !out_ready) |-> out_valid)

    // a stalled result keeps its pressure and altitude
    `BCP_ASSERT_POST(a_payload_hold, $past(out_valid && !out_ready) |-> $stable(pressure_pa) && $stable(altitude_cm))

    // altitude is held at zero while the ground offset is learned
    `BCP_ASSERT(a_cal_zero, out_valid && calibrating |-> altitude_cm == 22'sd0)

    // pressure and temperature stay within their saturation limits
    `BCP_ASSERT(a_ranges, out_valid |-> pressure_pa >= 17'd1000 && pressure_pa <= 17'd120000 && temperature_centi >= -15'sd4000 && temperature_centi <= 15'sd8500)

endmodule

bind baro_pressure_compensation_altitude_unit bcp_checker u_bcp_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .out_valid         (result_ch.valid),
    .out_ready         (result_ch.ready),
    .temperature_centi (result_ch.temperature_centi),
    .pressure_pa       (result_ch.pressure_pa),
    .altitude_cm       (result_ch.altitude_cm),
    .calibrating       (result_ch.calibrating)
);
